// ===== rtl/lcube_pkg.sv =====
// Shared types and constants for the LED cube PWM refresh frame buffer.
package lcube_pkg;

	// Fixed geometry of one buffer plane.
	localparam int BYTES_PER_CHAIN_LAYER = 12;
	localparam int LAYER_COUNT           = 8;
	localparam logic [3:0] LAST_BYTE     = 4'(BYTES_PER_CHAIN_LAYER - 1);

	// Channel numbering: 1..96 on chain B, 97..192 on chain A.
	localparam logic [7:0] CHANNEL_MAX   = 8'd192;
	localparam logic [7:0] CHAIN_A_FIRST = 8'd97;

	// A PWM count runs up to the largest supported step count of 16.
	localparam int CNT_W = 5;

	// Stream word widths.
	localparam int ACT_W       = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// Action codes on the input stream.
	typedef enum logic [ACT_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_SET    = 3'd1,
		ACT_FILL   = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_COMMIT = 3'd4
	} act_t;

	// Operations carried from the front part to the back part.
	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_SET,
		CMD_FILL,
		CMD_COMMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [2:0]       layer;
		logic [3:0]       byte_ix;
		logic             chain_a;
		logic [2:0]       bit_ix;
		logic [CNT_W-1:0] count;
		logic             fill_val;
	} cmd_t;

	// Back part sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_TICK,
		BK_SET,
		BK_FILL
	} bk_state_t;

endpackage

// ===== rtl/lcube_front.sv =====
// Front part: accepts input words, maps level and channel, and queues commands.
module lcube_front #(
	parameter int PWM_STEP_COUNT = 8
) (
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lcube_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [lcube_pkg::ACT_W-1:0]        s_tuser,
	input  logic                               clearing,
	output logic                               q_valid,
	input  logic                               q_ready,
	output lcube_pkg::cmd_t                    q_cmd
);
	import lcube_pkg::*;

	localparam logic [CNT_W-1:0] STEPS = CNT_W'(PWM_STEP_COUNT);

	logic [3:0]       layer;
	logic [7:0]       channel;
	logic [7:0]       level;
	logic             fill_on;
	logic             chain_a;
	logic [7:0]       idx;
	logic             set_ok;
	logic             keep;
	logic [CNT_W-1:0] count;
	logic [13:0]      scaled;
	logic [13:0]      quot;

	assign layer   = s_tdata[3:0];
	assign channel = s_tdata[11:4];
	assign level   = s_tdata[19:12];
	assign fill_on = s_tdata[20];

	// Perceptual level to PWM count; the general case divides by 255
	// as (x + x/256 + 1) / 256, exact for these operand sizes.
	always_comb begin
		scaled = 14'(level) * 14'(PWM_STEP_COUNT) + 14'd127;
		quot   = (scaled + (scaled >> 8) + 14'd1) >> 8;
		if (level == 8'd0) begin
			count = '0;
		end else if (PWM_STEP_COUNT == 8) begin
			priority if (level <= 8'd23) count = CNT_W'(1);
			else if (level <= 8'd63) count = CNT_W'(3);
			else if (level <= 8'd143) count = CNT_W'(5);
			else if (level <= 8'd223) count = CNT_W'(7);
			else count = CNT_W'(8);
		end else if (PWM_STEP_COUNT == 4) begin
			priority if (level <= 8'd31) count = CNT_W'(1);
			else if (level <= 8'd95) count = CNT_W'(2);
			else if (level <= 8'd191) count = CNT_W'(3);
			else count = CNT_W'(4);
		end else begin
			priority if (quot == 14'd0) count = CNT_W'(1);
			else if (quot > 14'(PWM_STEP_COUNT)) count = STEPS;
			else count = quot[CNT_W-1:0];
		end
	end

	// Channel to chain, byte and bit position.
	assign chain_a = channel >= CHAIN_A_FIRST;
	assign idx     = chain_a ? channel - CHAIN_A_FIRST : channel - 8'd1;
	assign set_ok  = (layer < 4'(LAYER_COUNT)) && (channel != 8'd0) &&
	                 (channel <= CHANNEL_MAX);

	// Build the command; dropped actions are accepted but never queued.
	always_comb begin
		q_cmd          = '0;
		q_cmd.layer    = layer[2:0];
		q_cmd.byte_ix  = idx[3] ? {idx[6:4], 1'b0} : {idx[6:4], 1'b1};
		q_cmd.chain_a  = chain_a;
		q_cmd.bit_ix   = idx[2:0];
		q_cmd.count    = count;
		q_cmd.fill_val = fill_on;
		keep           = 1'b0;
		unique case (act_t'(s_tuser)) 
			ACT_TICK: begin
				q_cmd.op = CMD_TICK;
				keep     = 1'b1;
			end
			ACT_SET: begin
				q_cmd.op = CMD_SET;
				keep     = set_ok;
			end
			ACT_FILL: begin
				q_cmd.op = CMD_FILL;
				keep     = 1'b1;
			end
			ACT_CLEAR: begin
				q_cmd.op       = CMD_FILL;
				q_cmd.fill_val = 1'b0;
				keep           = 1'b1;
			end
			ACT_COMMIT: begin
				q_cmd.op = CMD_COMMIT;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// No word is taken while the memory is being cleared after reset.
	assign s_tready = q_ready && !clearing;
	assign q_valid  = s_tvalid && !clearing && keep;

endmodule

// ===== rtl/lcube_queue.sv =====
// Two-entry command queue between the front and back parts.
module lcube_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  lcube_pkg::cmd_t wr_cmd,
	output logic            rd_valid,
	input  logic            rd_ready,
	output lcube_pkg::cmd_t rd_cmd
);
	import lcube_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd   = ent_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wr_cmd;
	end

endmodule

// ===== rtl/lcube_back.sv =====
// Back part: plane memory, command sequencer and the result word pipeline.
module lcube_back #(
	parameter int PWM_STEP_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  lcube_pkg::cmd_t                    cmd,
	output logic                               clearing,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lcube_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tlast
);
	import lcube_pkg::*;

	// Address = {buffer, phase, layer, byte slot}.
	localparam int PH_W  = (PWM_STEP_COUNT > 1) ? $clog2(PWM_STEP_COUNT) : 1;
	localparam int AW    = PH_W + 8;
	localparam int DEPTH = 2 ** AW;
	localparam int SC_W  = $clog2(PWM_STEP_COUNT + 1);
	localparam logic [PH_W-1:0] LAST_PH = PH_W'(PWM_STEP_COUNT - 1);
	localparam logic [SC_W-1:0] SC_END  = SC_W'(PWM_STEP_COUNT);

	logic [15:0]     mem [DEPTH];

	bk_state_t       state_q, state_d;
	cmd_t            cur_q;
	logic            front_q;
	logic [2:0]      scan_layer_q;
	logic [PH_W-1:0] phase_q;
	logic [3:0]      k_q;
	logic [SC_W-1:0] sc_q;
	logic [AW-1:0]   sw_q;
	logic [15:0]     rmw_q;

	logic [15:0]     rd_data_s1;
	logic            rd_valid_s1;
	logic [2:0]      layer_s1;
	logic            last_s1;

	logic            out_valid_q;
	logic [2:0]      out_layer_q;
	logic [15:0]     out_word_q;
	logic            out_last_q;

	logic            pop;
	logic            s1_move;
	logic            issue;
	logic            tick_done;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   rmw_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [15:0]     wr_data;
	logic [CNT_W-1:0] wph;
	logic [7:0]      bit_mask;
	logic [15:0]     mask;

	// Result pipeline handshake: read stage feeds the output register.
	assign s1_move   = rd_valid_s1 && (!out_valid_q || m_tready);
	assign issue     = (state_q == BK_TICK) && (!rd_valid_s1 || s1_move);
	assign tick_done = issue && (k_q == LAST_BYTE);
	assign rd_addr   = {front_q, phase_q, scan_layer_q, k_q};
	assign rmw_addr  = {~front_q, sc_q[PH_W-1:0], cur_q.layer, cur_q.byte_ix};

	// Bit update for the phase being written back.
	assign wph      = CNT_W'(sc_q) - CNT_W'(1);
	assign bit_mask = 8'd1 << cur_q.bit_ix;
	assign mask     = cur_q.chain_a ? {bit_mask, 8'h00} : {8'h00, bit_mask};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory write control.
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = sw_q;
		wr_data   = '0;
		unique case (state_q)
			BK_CLEAR: begin
				wr_en = 1'b1;
				if (&sw_q) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.op)
						CMD_TICK:   state_d = BK_TICK;
						CMD_SET:    state_d = BK_SET;
						CMD_FILL:   state_d = BK_FILL;
						CMD_COMMIT: state_d = BK_IDLE;
						default:    state_d = BK_IDLE;
					endcase
				end
			end
			BK_TICK: begin
				if (tick_done) state_d = BK_IDLE;
			end
			BK_SET: begin
				wr_en   = sc_q != '0;
				wr_addr = {~front_q, wph[PH_W-1:0], cur_q.layer, cur_q.byte_ix};
				wr_data = (cur_q.count > wph) ? (rmw_q | mask) : (rmw_q & ~mask);
				if (sc_q == SC_END) state_d = BK_IDLE;
			end
			BK_FILL: begin
				wr_en   = 1'b1;
				wr_addr = {~front_q, sw_q[AW-2:0]};
				wr_data = {16{cur_q.fill_val}};
				if (&sw_q[AW-2:0]) state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign pop      = cmd_valid && cmd_ready;
	assign clearing = state_q == BK_CLEAR;

	// Buffer select, scan position and step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q      <= 1'b0;
			scan_layer_q <= '0;
			phase_q      <= '0;
			k_q          <= '0;
			sc_q         <= '0;
			sw_q         <= '0;
		end else begin
			if (pop && cmd.op == CMD_COMMIT) front_q <= ~front_q;
			if (state_q == BK_IDLE) begin
				k_q  <= '0;
				sc_q <= '0;
				sw_q <= '0;
			end
			if (issue) k_q <= k_q + 4'd1;
			if (state_q == BK_SET) sc_q <= sc_q + SC_W'(1);
			if (state_q == BK_CLEAR || state_q == BK_FILL) sw_q <= sw_q + AW'(1);
			if (tick_done) begin
				scan_layer_q <= scan_layer_q + 3'd1;
				if (scan_layer_q == 3'd7)
					phase_q <= (phase_q == LAST_PH) ? '0 : phase_q + PH_W'(1);
			end
		end
	end

	// Command latched when it is taken from the queue.
	always_ff @(posedge clk) begin
		if (pop) cur_q <= cmd;
	end

	// Plane memory: one write port, a scan read port and a read-modify-write port.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (issue) rd_data_s1 <= mem[rd_addr];
		rmw_q <= mem[rmw_addr];
	end

	// Read stage and output register valid control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) rd_valid_s1 <= 1'b1;
			else if (s1_move) rd_valid_s1 <= 1'b0;
			if (s1_move) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Read stage sideband and output register payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			layer_s1 <= scan_layer_q;
			last_s1  <= k_q == LAST_BYTE;
		end
		if (s1_move) begin
			out_layer_q <= layer_s1;
			out_word_q  <= rd_data_s1;
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_word_q[7:0], out_word_q[15:8], out_layer_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== rtl/led_cube_pwm_refresh_framebuffer.sv =====
// Top level of the LED cube PWM refresh frame buffer.
//
//  channel  | dir | word contents
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tuser: action; tdata: layer, channel, level, fill_on
//  m_axis   | out | tdata: layer_addr, byte_a, byte_b; tlast: last
//
// A tick streams its 12 words, set level rewrites one bit in each of the PWM_STEP_COUNT
// phases, commit swaps the buffers, and fill or clear writes all 2**(clog2(PWM_STEP_COUNT) + 7)
// words of the back buffer; their speed is set by the single write and scan ports of the plane memory.
// After reset a clearing pass writes all 2**(clog2(PWM_STEP_COUNT) + 8) words
// (2048 at eight steps), one per cycle, with s_tready low.
// A two-entry queue lets input words be taken while the back part works, and
// a registered read stage plus output register keep ticks streaming under stalls.
module led_cube_pwm_refresh_framebuffer #(
	parameter int PWM_STEP_COUNT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// tdata from bit 0: layer[3:0], channel[11:4], level[19:12], fill_on[20], zero
	input  logic [lcube_pkg::IN_TDATA_W-1:0]   s_tdata,
	// tuser from bit 0: action[2:0]
	input  logic [lcube_pkg::ACT_W-1:0]        s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// tdata from bit 0: layer_addr[2:0], byte_a[10:3], byte_b[18:11], zero
	output logic [lcube_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tlast
);
	import lcube_pkg::*;

	cmd_t fq_cmd;
	cmd_t bq_cmd;
	logic fq_valid;
	logic fq_ready;
	logic bq_valid;
	logic bq_ready;
	logic clearing;

	// Front part: decode and classify.
	lcube_front #(
		.PWM_STEP_COUNT(PWM_STEP_COUNT)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.clearing(clearing),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_cmd   (fq_cmd)
	);

	// Command queue.
	lcube_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_cmd  (fq_cmd),
		.rd_valid(bq_valid),
		.rd_ready(bq_ready),
		.rd_cmd  (bq_cmd)
	);

	// Back part: memory and result stream.
	lcube_back #(
		.PWM_STEP_COUNT(PWM_STEP_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(bq_valid),
		.cmd_ready(bq_ready),
		.cmd      (bq_cmd),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/lcube_checker.sv =====
// Port-level checks for the LED cube refresh frame buffer, bound to the top level.
module lcube_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [lcube_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic [lcube_pkg::ACT_W-1:0]        s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [lcube_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                               m_tlast
);

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed while stalled");

	// The padding bits of a result word are zero.
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("result word padding not zero");

	// All words of one refresh carry the same layer address.
	a_same_layer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			!m_tvalid || m_tdata[2:0] == $past(m_tdata[2:0]))
		else $error("layer address changed inside a refresh");

	// The word after a finished refresh addresses the next layer.
	a_next_layer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=>
			!m_tvalid || m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1)
		else $error("refresh did not advance to the next layer");

endmodule

bind led_cube_pwm_refresh_framebuffer lcube_checker u_lcube_checker (.*);
